### src/rle_byte_encoder_assert.svh
// Assertion macros for the run-length encoder.
`ifndef RLE_BYTE_ENCODER_ASSERT_SVH
`define RLE_BYTE_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RBE_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rle_byte_encoder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RBE_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rle_byte_encoder: next-cycle check failed");

`endif

### src/rbe_pkg.sv
package rbe_pkg;

  // Group lengths fit in 7 bits for any run limit up to 127.
  localparam int LEN_W = 7;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic {
    K_LIT = 1'b0,
    K_RUN = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_end;
    logic       stream_end;
  } out_item_t;

  // One group to emit: literal group from a bank, or a run.
  typedef struct packed {
    kind_t            kind;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             burst_end;
    logic             stream_end;
  } cmd_t;

  // Literal buffer write from the front.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  // Bank release from the back once a literal group is read out.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

### src/rbe_queue.sv
module rbe_queue
  import rbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t                entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = entry[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/rbe_front.sv
module rbe_front
  import rbe_pkg::*;
#(
  parameter int MAX_RUN
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     raw_valid,
  output logic     raw_stall,
  input  in_item_t raw_item,
  output logic     q_push,
  output cmd_t     q_cmd,
  input  logic     q_full,
  output mem_wr_t  mwr,
  input  rel_t     rel
);

  localparam int CW = $clog2(MAX_RUN + 1);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_LIT  = 3'b010,
    M_RUN  = 3'b100
  } mode_t;

  mode_t          mode, mode_next;
  logic [CW-1:0]  lit_cnt, lit_cnt_next;
  logic [CW-1:0]  run_cnt, run_cnt_next;
  logic [7:0]     last_byte, last_byte_next;
  logic [7:0]     run_byte, run_byte_next;
  logic           cur_bank;
  logic [1:0]     busy, busy_next;
  logic           hold_valid;
  cmd_t           hold;

  logic           acc;
  logic [7:0]     b;
  logic [CW-1:0]  cnt_inc;
  logic [CW-1:0]  rc;
  cmd_t           ca, cb;
  logic           ca_v, cb_v;
  logic           lit_used;

  function automatic cmd_t mk_cmd(kind_t k, logic bk, logic [LEN_W-1:0] n, logic [7:0] d);
    cmd_t c;
    c            = '0;
    c.kind       = k;
    c.bank       = bk;
    c.len        = n;
    c.data       = d;
    return c;
  endfunction

  // Hold off input while a second command waits, the queue is full,
  // or the bank about to be written is still being read out.
  assign raw_stall = hold_valid || q_full || busy[cur_bank];
  assign acc       = raw_valid && !raw_stall;
  assign b         = raw_item.data_byte;
  assign cnt_inc   = lit_cnt + 1'b1;
  assign rc        = run_cnt + 1'b1;

  // Classify the transaction and build up to two commands
  always_comb begin
    mode_next      = mode;
    lit_cnt_next   = lit_cnt;
    run_cnt_next   = run_cnt;
    last_byte_next = last_byte;
    run_byte_next  = run_byte;
    ca             = '0;
    cb             = '0;
    ca_v           = 1'b0;
    cb_v           = 1'b0;
    lit_used       = 1'b0;
    mwr            = '0;
    if (acc) begin
      unique case (mode)
        M_LIT: begin
          if (b == last_byte) begin
            // Repeat: emit all buffered bytes but the last, start a run of two
            if (lit_cnt > CW'(1)) begin
              ca_v     = 1'b1;
              ca       = mk_cmd(K_LIT, cur_bank, LEN_W'(lit_cnt - 1'b1), 8'd0);
              lit_used = 1'b1;
            end
            mode_next     = M_RUN;
            lit_cnt_next  = '0;
            run_byte_next = b;
            run_cnt_next  = CW'(2);
          end else begin
            mwr.en         = 1'b1;
            mwr.bank       = cur_bank;
            mwr.addr       = LEN_W'(lit_cnt);
            mwr.data       = b;
            last_byte_next = b;
            if (cnt_inc == CW'(MAX_RUN)) begin
              ca_v         = 1'b1;
              ca           = mk_cmd(K_LIT, cur_bank, LEN_W'(cnt_inc), 8'd0);
              lit_used     = 1'b1;
              mode_next    = M_IDLE;
              lit_cnt_next = '0;
            end else begin
              lit_cnt_next = cnt_inc;
            end
          end
        end
        M_RUN: begin
          if (b == run_byte) begin
            if (rc >= CW'(MAX_RUN)) begin
              ca_v         = 1'b1;
              ca           = mk_cmd(K_RUN, cur_bank, LEN_W'(rc), run_byte);
              mode_next    = M_IDLE;
              run_cnt_next = '0;
            end else begin
              run_cnt_next = rc;
            end
          end else begin
            // Close the run and open a literal with this byte
            ca_v           = 1'b1;
            ca             = mk_cmd(K_RUN, cur_bank, LEN_W'(run_cnt), run_byte);
            run_cnt_next   = '0;
            mwr.en         = 1'b1;
            mwr.bank       = cur_bank;
            mwr.addr       = '0;
            mwr.data       = b;
            last_byte_next = b;
            lit_cnt_next   = CW'(1);
            mode_next      = M_LIT;
          end
        end
        default: begin
          // Idle: open a literal with this byte
          mwr.en         = 1'b1;
          mwr.bank       = cur_bank;
          mwr.addr       = '0;
          mwr.data       = b;
          last_byte_next = b;
          lit_cnt_next   = CW'(1);
          mode_next      = M_LIT;
        end
      endcase

      // Flush the pending group after the final byte
      if (raw_item.is_last) begin
        if (mode_next == M_LIT) begin
          cb_v     = 1'b1;
          cb       = mk_cmd(K_LIT, cur_bank, LEN_W'(lit_cnt_next), 8'd0);
          lit_used = 1'b1;
        end else if (mode_next == M_RUN) begin
          cb_v = 1'b1;
          cb   = mk_cmd(K_RUN, cur_bank, LEN_W'(run_cnt_next), run_byte_next);
        end
        mode_next    = M_IDLE;
        lit_cnt_next = '0;
        run_cnt_next = '0;
      end

      // Mark the final command of this transaction
      if (cb_v) begin
        cb.burst_end  = 1'b1;
        cb.stream_end = raw_item.is_last;
      end else if (ca_v) begin
        ca.burst_end  = 1'b1;
        ca.stream_end = raw_item.is_last;
      end
    end
  end

  // Push the held command first, else the first new one
  assign q_push = (acc && (ca_v || cb_v)) || (hold_valid && !q_full);
  assign q_cmd  = hold_valid ? hold : (ca_v ? ca : cb);

  // Track banks in use by the back
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (acc && lit_used) begin
      busy_next[cur_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    last_byte <= last_byte_next;
    run_byte  <= run_byte_next;
    if (acc && ca_v && cb_v) begin
      hold <= cb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      lit_cnt    <= '0;
      run_cnt    <= '0;
      cur_bank   <= 1'b0;
      busy       <= '0;
      hold_valid <= 1'b0;
    end else begin
      mode     <= mode_next;
      lit_cnt  <= lit_cnt_next;
      run_cnt  <= run_cnt_next;
      busy     <= busy_next;
      if (acc && lit_used) begin
        cur_bank <= !cur_bank;
      end
      if (acc && ca_v && cb_v) begin
        hold_valid <= 1'b1;
      end else if (hold_valid && !q_full) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

### src/rbe_back.sv
module rbe_back
  import rbe_pkg::*;
#(
  parameter int MAX_RUN
)
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  input  mem_wr_t   mwr,
  output rel_t      rel,
  output logic      enc_valid,
  input  logic      enc_stall,
  output out_item_t enc_item
);

  localparam int AW = $clog2(MAX_RUN);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LIT  = 3'b010,
    B_RUN  = 3'b100
  } bstate_t;

  logic [7:0]    mem [2][MAX_RUN];
  logic [7:0]    rd_data;
  logic          rd_en;
  logic          rd_bank;
  logic [AW-1:0] rd_addr;

  bstate_t       state, state_next;
  cmd_t          cur, cur_next;
  logic [AW-1:0] idx, idx_next;
  logic          can_load;
  logic          load;
  out_item_t     ld_item;
  logic          fin;

  // Double-banked literal buffer
  always_ff @(posedge clk) begin
    if (mwr.en) begin
      mem[mwr.bank][mwr.addr[AW-1:0]] <= mwr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_bank][rd_addr];
    end
  end

  assign can_load = !enc_valid || !enc_stall;
  assign fin      = (LEN_W'(idx) == (cur.len - 1'b1));

  // Sequence header, literal bytes and run byte
  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    q_pop      = 1'b0;
    load       = 1'b0;
    ld_item    = '0;
    rd_en      = 1'b0;
    rd_bank    = cur.bank;
    rd_addr    = idx + 1'b1;
    rel        = '0;
    unique case (state)
      B_LIT: begin
        if (can_load) begin
          load             = 1'b1;
          ld_item.out_byte = rd_data;
          if (fin) begin
            ld_item.burst_end  = cur.burst_end;
            ld_item.stream_end = cur.stream_end;
            rel.valid          = 1'b1;
            rel.bank           = cur.bank;
            state_next         = B_IDLE;
          end else begin
            rd_en    = 1'b1;
            idx_next = idx + 1'b1;
          end
        end
      end
      B_RUN: begin
        if (can_load) begin
          load               = 1'b1;
          ld_item.out_byte   = cur.data;
          ld_item.burst_end  = cur.burst_end;
          ld_item.stream_end = cur.stream_end;
          state_next         = B_IDLE;
        end
      end
      default: begin
        if (!q_empty && can_load) begin
          q_pop    = 1'b1;
          load     = 1'b1;
          cur_next = head;
          if (head.kind == K_LIT) begin
            ld_item.out_byte = 8'd0 - {1'b0, head.len};
            rd_en            = 1'b1;
            rd_bank          = head.bank;
            rd_addr          = '0;
            idx_next         = '0;
            state_next       = B_LIT;
          end else begin
            ld_item.out_byte = {1'b0, head.len};
            state_next       = B_RUN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    if (load) begin
      enc_item <= ld_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      enc_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        enc_valid <= 1'b1;
      end else if (!enc_stall) begin
        enc_valid <= 1'b0;
      end
    end
  end

endmodule

### src/rle_byte_encoder.sv
// Path: a closed group's command is queued, then the back registers its header byte onto enc_item.
// Output: one byte per cycle unless stalled; n literals go out as n + 1 bytes, a run as 2.
// Input: one byte per cycle while the 2-entry command queue has room; an input that closes two
// groups stalls until its second command is queued; a new literal waits for its buffer bank.
// Reset: synchronous rst clears mode, counters, queue and output valid; buffers keep data.
`include "rle_byte_encoder_assert.svh"

module rle_byte_encoder
  import rbe_pkg::*;
#(
  parameter int MAX_RUN = 63
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      raw_valid,
  output logic      raw_stall,
  input  in_item_t  raw_item,
  output logic      enc_valid,
  input  logic      enc_stall,
  output out_item_t enc_item
);

  logic    q_push;
  cmd_t    q_cmd;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  cmd_t    q_head;
  mem_wr_t mwr;
  rel_t    rel;

  rbe_front #(.MAX_RUN(MAX_RUN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw_item  (raw_item),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_full    (q_full),
    .mwr       (mwr),
    .rel       (rel)
  );

  rbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rbe_back #(.MAX_RUN(MAX_RUN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .mwr       (mwr),
    .rel       (rel),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .enc_item  (enc_item)
  );

  `RBE_CHECK_NOW(a_no_push_when_full, q_push && q_full, q_pop)
  `RBE_CHECK_NOW(a_no_pop_when_empty, q_pop, !q_empty)
  `RBE_CHECK_NOW(a_write_on_accept, mwr.en, raw_valid && !raw_stall)
  `RBE_CHECK_NOW(a_stream_end_closes_burst, enc_valid && enc_item.stream_end, enc_item.burst_end)

endmodule

### sim/tb_rle_byte_encoder.sv
module tb_rle_byte_encoder
  import rbe_pkg::*;
();

  localparam int MAX_RUN     = 63;
  localparam int ITEMS       = 370;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int LIMIT_CYC   = 4000000;
  localparam int HALF_PERIOD = 6;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LIT  = 2'd1,
    ST_RUN  = 2'd2
  } enc_mode_t;

  // Predicts the encoded byte stream and checks the block's output against it.
  class rle_scoreboard;
    enc_mode_t  mode;
    logic [7:0] lit_buf [MAX_RUN];
    int         lit_cnt;
    logic [7:0] run_val;
    int         run_cnt;
    out_item_t  burst[$];
    out_item_t  exp_q[$];
    int         errors;

    function new();
      mode    = ST_IDLE;
      lit_cnt = 0;
      run_val = '0;
      run_cnt = 0;
      errors  = 0;
      foreach (lit_buf[i]) lit_buf[i] = '0;
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function void emit(logic [7:0] b);
      out_item_t r;
      r.out_byte   = b;
      r.burst_end  = 1'b0;
      r.stream_end = 1'b0;
      burst.push_back(r);
    endfunction

    function void emit_literals(int cnt);
      if (cnt == 0 || cnt > MAX_RUN) return;
      emit(8'(256 - cnt));
      for (int i = 0; i < cnt; i++) emit(lit_buf[i]);
    endfunction

    function void emit_run();
      emit(8'(run_cnt));
      emit(run_val);
    endfunction

    function void start_literal(logic [7:0] b);
      lit_buf[0] = b;
      lit_cnt    = 1;
      mode       = ST_LIT;
    endfunction

    // Advance the encoder by one input transaction and queue its output bytes.
    function void note_input(in_item_t it);
      logic [7:0] b;
      logic       fin;
      b   = it.data_byte;
      fin = it.is_last;
      burst.delete();
      case (mode)
        ST_LIT: begin
          if (b == lit_buf[lit_cnt - 1]) begin
            // a repeat moves the last literal into a new run
            emit_literals(lit_cnt - 1);
            lit_cnt = 0;
            run_val = b;
            run_cnt = 2;
            mode    = ST_RUN;
          end else if (lit_cnt < MAX_RUN) begin
            lit_buf[lit_cnt] = b;
            lit_cnt++;
            if (lit_cnt == MAX_RUN) begin
              emit_literals(lit_cnt);
              lit_cnt = 0;
              mode    = ST_IDLE;
            end
          end else begin
            emit_literals(lit_cnt);
            start_literal(b);
          end
        end
        ST_RUN: begin
          if (b == run_val) begin
            run_cnt++;
            if (run_cnt >= MAX_RUN) begin
              emit_run();
              run_cnt = 0;
              mode    = ST_IDLE;
            end
          end else begin
            emit_run();
            run_cnt = 0;
            start_literal(b);
          end
        end
        default: start_literal(b);
      endcase
      // flush whatever group is open on the final byte
      if (fin) begin
        if (mode == ST_LIT) emit_literals(lit_cnt);
        else if (mode == ST_RUN) emit_run();
        lit_cnt = 0;
        run_cnt = 0;
        mode    = ST_IDLE;
      end
      if (burst.size() > 0) begin
        burst[burst.size() - 1].burst_end  = 1'b1;
        burst[burst.size() - 1].stream_end = fin;
      end
      foreach (burst[i]) exp_q.push_back(burst[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (exp_q.size() == 0) begin
        $error("unexpected output transaction: out_byte %02h", got.out_byte);
        errors++;
        return;
      end
      want = exp_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.burst_end !== want.burst_end) begin
        $error("burst_end: expected %0b, got %0b", want.burst_end, got.burst_end);
        errors++;
      end
      if (got.stream_end !== want.stream_end) begin
        $error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      raw_valid = 1'b0;
  logic      raw_stall;
  in_item_t  raw_item  = '0;
  logic      enc_valid;
  logic      enc_stall = 1'b0;
  out_item_t enc_item;

  rle_scoreboard sb;
  bit            hold_req;
  bit            quiet;
  int            n_sent;
  logic [7:0]    prev_byte;

  rle_byte_encoder #(.MAX_RUN(MAX_RUN)) dut (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw_item  (raw_item),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .enc_item  (enc_item)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Mostly short idle gaps, now and then a long one; none in a quiet stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 8);
    return $urandom_range(55, 70);
  endfunction

  // Offer one byte, hold it until accepted, then maybe idle.
  task automatic send_byte(logic [7:0] b, logic fin);
    in_item_t it;
    int       gap;
    it.data_byte = b;
    it.is_last   = fin;
    raw_item  <= it;
    raw_valid <= 1'b1;
    do @(posedge clk); while (raw_stall);
    sb.note_input(it);
    prev_byte = b;
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      raw_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(int len, logic fin);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) send_byte(b, fin && (i == len - 1));
  endtask

  task automatic send_literals(int len, logic fin);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == prev_byte);
      send_byte(b, fin && (i == len - 1));
    end
  endtask

  // Bytes mostly from 00, FF and the previous byte so repeats and broken groups come often.
  task automatic send_noise(int len);
    logic [7:0] b;
    int         r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 3);
      case (r)
        0: b = 8'($urandom_range(0, 255));
        1: b = 8'h00;
        2: b = 8'hFF;
        default: b = prev_byte;
      endcase
      send_byte(b, $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: check each accepted output transaction, then pick the next stall.
  initial begin
    int   hold_cnt;
    int   stall_left;
    logic nxt;
    hold_cnt   = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && enc_valid && !enc_stall) sb.check_result(enc_item);
      if (hold_req) begin
        nxt = 1'b1;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
      end else if (stall_left > 0) begin
        nxt = 1'b1;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        nxt = (stall_left > 0);
        if (nxt) stall_left--;
      end
      enc_stall <= nxt;
    end
  end

  initial begin
    int r;
    bit hold_done;
    bit pause_done;
    sb         = new();
    hold_req   = 1'b0;
    quiet      = 1'b0;
    n_sent     = 0;
    prev_byte  = '0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single byte streams at the value extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // repeat right after one literal: run only
    send_byte(8'h3C, 1'b0);
    send_byte(8'h3C, 1'b1);
    // repeat after two literals: one-byte literal group, a run, then a literal
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    // several literals, a run of three, broken by a new literal
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
    // alternating bit patterns stay literal
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    // final byte repeats a run in progress
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b1);

    // full groups: run past the limit, literal exactly full, literal past full
    send_run(MAX_RUN + 2, 1'b0);
    send_literals(MAX_RUN, 1'b0);
    send_literals(MAX_RUN + 1, 1'b1);

    while (n_sent < ITEMS) begin
      // hold the output long enough for the block to stall its input
      if (!hold_done && n_sent >= 180) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        send_literals(MAX_RUN + 1, 1'b0);
        send_run(10, 1'b1);
      end
      // pause the input until every queued byte has come out
      if (!pause_done && n_sent >= 250) begin
        pause_done = 1'b1;
        raw_valid <= 1'b0;
        wait_drain();
      end
      quiet = (n_sent >= 280 && n_sent < 320);
      r = $urandom_range(0, 99);
      if (r < 40) send_run(pick_len(), $urandom_range(0, 6) == 0);
      else if (r < 75) send_literals(pick_len(), $urandom_range(0, 6) == 0);
      else send_noise($urandom_range(1, 10));
    end
    quiet = 1'b0;
    send_byte(8'($urandom_range(0, 255)), 1'b1);

    raw_valid <= 1'b0;
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYC);
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/rbe_pkg.sv
src/rbe_queue.sv
src/rbe_front.sv
src/rbe_back.sv
src/rle_byte_encoder.sv
sim/tb_rle_byte_encoder.sv
